/* rtl/wsdm_pkg.sv */
package wsdm_pkg;

  localparam int NUM_CH        = 3;
  localparam int CH_W          = 2;
  localparam int DATA_W        = 32;
  localparam int HELD_W        = 5;
  localparam int DEFAULT_DEPTH = 16;

  // Channel codes; the fourth code carries no series.
  localparam logic [CH_W-1:0] CH_ALTITUDE  = 2'd0;
  localparam logic [CH_W-1:0] CH_LATITUDE  = 2'd1;
  localparam logic [CH_W-1:0] CH_LONGITUDE = 2'd2;
  localparam logic [CH_W-1:0] CH_NONE      = 2'd3;

  // Status of the statistics unit as seen by the top-level sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } stat_status_t;

endpackage

/* rtl/wsdm_window_ram.sv */
module wsdm_window_ram #(
  parameter int ADDR_W = 6,
  parameter int DEPTH  = 48
) (
  input  logic                           clk,
  input  logic                           wr_en,
  input  logic [ADDR_W-1:0]              wr_addr,
  input  logic [wsdm_pkg::DATA_W-1:0]    wr_data,
  input  logic                           rd_en,
  input  logic [ADDR_W-1:0]              rd_addr,
  output logic [wsdm_pkg::DATA_W-1:0]    rd_data
);

  logic [wsdm_pkg::DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/wsdm_stat_unit.sv */
module wsdm_stat_unit #(
  parameter int WINDOW_DEPTH = wsdm_pkg::DEFAULT_DEPTH,
  parameter int CW           = $clog2(WINDOW_DEPTH + 1),
  parameter int AW           = $clog2(WINDOW_DEPTH)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [CW-1:0]                n,
  output logic                         rd_en,
  output logic [AW-1:0]                rd_slot,
  input  logic [wsdm_pkg::DATA_W-1:0]  rd_data,
  output wsdm_pkg::stat_status_t       status,
  output logic [wsdm_pkg::DATA_W-1:0]  dev
);

  localparam int SW   = 33 + CW;
  localparam int QW   = 64 + CW;
  localparam int NW   = QW + CW;
  localparam int DVW  = 2 * CW;
  localparam int CNTW = $clog2(NW + 1);
  localparam int AddW = NW + 1;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_WALK = 4'd1;
  localparam logic [3:0] S_MUL1 = 4'd2;
  localparam logic [3:0] S_MUL2 = 4'd3;
  localparam logic [3:0] S_SUB  = 4'd4;
  localparam logic [3:0] S_DIV  = 4'd5;
  localparam logic [3:0] S_SQRT = 4'd6;

  logic [3:0]            state;
  logic [CW-1:0]         n_q;
  logic [CW-1:0]         issue_cnt;
  logic                  v1;
  logic                  v2;
  logic signed [SW-1:0]  x_q;
  logic [63:0]           sq_q;
  logic signed [SW-1:0]  sum;
  logic [QW-1:0]         sumsq;
  logic [NW-1:0]         acc;
  logic [NW-1:0]         mc;
  logic [SW-1:0]         mb;
  logic [NW-1:0]         num;
  logic [DVW-1:0]        rem;
  logic [DVW-1:0]        div_q;
  logic [CNTW-1:0]       cnt;
  logic [31:0]           root;
  logic [33:0]           srem;
  logic [63:0]           sval;
  logic                  done;

  logic [31:0]           mag;
  logic [SW-1:0]         sum_mag;
  logic [DVW:0]          div_t;
  logic [33:0]           sq_r4;
  logic [AddW-1:0]       add_a;
  logic [AddW-1:0]       add_b;
  logic                  add_sub;
  logic [AddW:0]         add_y;
  logic                  add_c;

  assign mag     = rd_data[31] ? (32'd0 - rd_data) : rd_data;
  assign sum_mag = sum[SW-1] ? (SW'(0) - SW'(sum)) : SW'(sum);
  assign div_t   = {rem, num[NW-1]};
  assign sq_r4   = {srem[31:0], sval[63:62]};

  assign rd_en   = (state == S_WALK) && (issue_cnt < n_q);
  assign rd_slot = issue_cnt[AW-1:0];

  // The one wide adder that the multiply, subtract, divide and root phases share.
  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_sub = 1'b0;
    case (state)
      S_MUL1, S_MUL2: begin
        add_a = AddW'(acc);
        add_b = AddW'(mc);
      end
      S_SUB: begin
        add_a   = AddW'(num);
        add_b   = AddW'(acc);
        add_sub = 1'b1;
      end
      S_DIV: begin
        add_a   = AddW'(div_t);
        add_b   = AddW'(div_q);
        add_sub = 1'b1;
      end
      S_SQRT: begin
        add_a   = AddW'(sq_r4);
        add_b   = AddW'({root, 2'b01});
        add_sub = 1'b1;
      end
      default: begin
        add_a = '0;
      end
    endcase
  end

  assign add_y = {1'b0, add_a} + {1'b0, (add_sub ? ~add_b : add_b)} + (AddW + 1)'(add_sub);
  assign add_c = add_y[AddW];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      v1    <= 1'b0;
      v2    <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= (state == S_SQRT) && (cnt == '0);
      v1   <= rd_en;
      v2   <= v1;
      case (state)
        S_IDLE: begin
          if (start) begin
            n_q       <= n;
            issue_cnt <= '0;
            sum       <= '0;
            sumsq     <= '0;
            state     <= S_WALK;
          end
        end
        S_WALK: begin
          if (rd_en) begin
            issue_cnt <= issue_cnt + 1'b1;
          end
          if (!rd_en && !v1 && !v2) begin
            acc   <= '0;
            mc    <= NW'(sumsq);
            mb    <= SW'(n_q);
            cnt   <= CNTW'(CW);
            state <= S_MUL1;
          end
        end
        S_MUL1, S_MUL2: begin
          if (cnt != '0) begin
            if (mb[0]) begin
              acc <= add_y[NW-1:0];
            end
            mc  <= mc << 1;
            mb  <= mb >> 1;
            cnt <= cnt - 1'b1;
          end else if (state == S_MUL1) begin
            num   <= acc;
            acc   <= '0;
            mc    <= NW'(sum_mag);
            mb    <= sum_mag;
            cnt   <= CNTW'(SW);
            state <= S_MUL2;
          end else begin
            state <= S_SUB;
          end
        end
        S_SUB: begin
          num   <= add_y[NW-1:0];
          div_q <= DVW'(n_q) * DVW'(n_q);
          rem   <= '0;
          cnt   <= CNTW'(NW);
          state <= S_DIV;
        end
        S_DIV: begin
          if (cnt != '0) begin
            rem <= add_c ? add_y[DVW-1:0] : div_t[DVW-1:0];
            num <= {num[NW-2:0], add_c};
            cnt <= cnt - 1'b1;
          end else begin
            sval  <= num[63:0];
            srem  <= '0;
            root  <= '0;
            cnt   <= CNTW'(32);
            state <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (cnt != '0) begin
            srem <= add_c ? add_y[33:0] : sq_r4;
            root <= {root[30:0], add_c};
            sval <= sval << 2;
            cnt  <= cnt - 1'b1;
          end else begin
            dev   <= root;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (v1) begin
        x_q  <= SW'($signed(rd_data));
        sq_q <= 64'(mag) * 64'(mag);
      end
      if (v2) begin
        sum   <= sum + x_q;
        sumsq <= sumsq + QW'(sq_q);
      end
    end
  end

  assign status.busy = (state != S_IDLE);
  assign status.done = done;

  a_walk_reads_in_window: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> (issue_cnt < n_q) && (state == S_WALK))
    else $error("window read beyond held samples");

  a_done_from_sqrt: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == S_SQRT)
    else $error("deviation reported outside the root phase");

  a_start_when_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && start) |=> (state == S_WALK))
    else $error("start not taken");

endmodule

/* rtl/windowed_std_deviation_monitor.sv */
// Windowed standard deviation monitor. Each s_* transfer carries one sample for
// one channel (altitude, latitude or longitude, selected by s_tuser); the sample
// enters that channel's ring of the last WINDOW_DEPTH samples and one m_*
// transfer reports the floor of the population standard deviation of the held
// samples, the held count, and an unsteady flag that is set when any channel's
// latest deviation is above its limit register. A sample with channel code
// three is taken and dropped with no result. The block works on one sample at
// a time and holds s_tready low meanwhile; a previous result still waiting in
// the output register holds off the next sample as well. One shared wide adder
// performs, one bit per cycle, the two shift-add products, the division by n
// squared and the digit-by-digit square root, after a walk over the window
// memory that reads one sample per cycle. A finished result waits in the output
// register while the next sample is already being taken. Limit registers reset
// to all ones and are written through the cfg channel; indexes above two are
// ignored.
module windowed_std_deviation_monitor #(
  parameter int WINDOW_DEPTH = wsdm_pkg::DEFAULT_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [31:0]                   s_tdata,   // [31:0] sample
  input  logic [1:0]                    s_tuser,   // [1:0] channel
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [39:0]                   m_tdata,   // [31:0] deviation, [36:32] held_count
  output logic [2:0]                    m_tuser,   // [1:0] out_channel, [2] unsteady
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [1:0]                    cfg_index,
  input  logic [31:0]                   cfg_data
);

  localparam int CW     = $clog2(WINDOW_DEPTH + 1);
  localparam int AW     = $clog2(WINDOW_DEPTH);
  localparam int RAM_AW = AW + wsdm_pkg::CH_W;
  localparam int RAM_D  = wsdm_pkg::NUM_CH * (2 ** AW);

  localparam logic [1:0] T_IDLE = 2'd0;
  localparam logic [1:0] T_CALC = 2'd1;
  localparam logic [1:0] T_EMIT = 2'd2;

  logic [1:0]                        state;
  logic [wsdm_pkg::CH_W-1:0]         cur_ch;
  logic [CW-1:0]                     n_cur;
  logic                              start;
  logic [AW-1:0]                     slot      [wsdm_pkg::NUM_CH];
  logic [CW-1:0]                     count     [wsdm_pkg::NUM_CH];
  logic [31:0]                       last_dev  [wsdm_pkg::NUM_CH];
  logic [31:0]                       limit     [wsdm_pkg::NUM_CH];

  logic                              in_xfer;
  logic                              in_valid_ch;
  logic [AW:0]                       slot_inc;
  logic [CW-1:0]                     count_new;
  logic                              rd_en;
  logic [AW-1:0]                     rd_slot;
  logic [31:0]                       rd_data;
  logic [31:0]                       dev;
  wsdm_pkg::stat_status_t            status;
  logic                              out_free;
  logic                              unsteady;
  logic [CW+wsdm_pkg::HELD_W-1:0]    held_ext;

  assign s_tready    = (state == T_IDLE);
  assign cfg_ready   = 1'b1;
  assign in_xfer     = s_tvalid && s_tready;
  assign in_valid_ch = (s_tuser != wsdm_pkg::CH_NONE);
  assign slot_inc    = {1'b0, slot[s_tuser]} + 1'b1;
  assign count_new   = (count[s_tuser] < CW'(WINDOW_DEPTH)) ? count[s_tuser] + 1'b1
                                                             : count[s_tuser];
  assign out_free    = !m_tvalid || m_tready;
  assign held_ext    = (CW + wsdm_pkg::HELD_W)'(count[cur_ch]);

  always_comb begin
    unsteady = 1'b0;
    for (int c = 0; c < wsdm_pkg::NUM_CH; c++) begin
      if (last_dev[c] > limit[c]) begin
        unsteady = 1'b1;
      end
    end
  end

  wsdm_window_ram #(
    .ADDR_W (RAM_AW),
    .DEPTH  (RAM_D)
  ) u_ram (
    .clk     (clk),
    .wr_en   (in_xfer && in_valid_ch),
    .wr_addr ({s_tuser, slot[s_tuser]}),
    .wr_data (s_tdata),
    .rd_en   (rd_en),
    .rd_addr ({cur_ch, rd_slot}),
    .rd_data (rd_data)
  );

  wsdm_stat_unit #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .CW           (CW),
    .AW           (AW)
  ) u_stat (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .n       (n_cur),
    .rd_en   (rd_en),
    .rd_slot (rd_slot),
    .rd_data (rd_data),
    .status  (status),
    .dev     (dev)
  );

  // Limit registers. Writes are only expected while the block is idle.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < wsdm_pkg::NUM_CH; c++) begin
        limit[c] <= '1;
      end
    end else if (cfg_valid && cfg_ready) begin
      for (int c = 0; c < wsdm_pkg::NUM_CH; c++) begin
        if (cfg_index == wsdm_pkg::CH_W'(c)) begin
          limit[c] <= cfg_data;
        end
      end
    end
  end

  // Sequencer: take a sample, let the statistics unit run, then post the result.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= T_IDLE;
      start    <= 1'b0;
      m_tvalid <= 1'b0;
      for (int c = 0; c < wsdm_pkg::NUM_CH; c++) begin
        slot[c]     <= '0;
        count[c]    <= '0;
        last_dev[c] <= '0;
      end
    end else begin
      // A sample is only accepted in T_IDLE, so this pulses once per sample with a valid channel.
      start <= in_xfer && in_valid_ch;
      if (state == T_EMIT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        T_IDLE: begin
          if (in_xfer && in_valid_ch) begin
            slot[s_tuser]  <= (slot_inc == (AW + 1)'(WINDOW_DEPTH)) ? '0 : slot_inc[AW-1:0];
            count[s_tuser] <= count_new;
            cur_ch         <= s_tuser;
            n_cur          <= count_new;
            state          <= T_CALC;
          end
        end
        T_CALC: begin
          if (status.done) begin
            last_dev[cur_ch] <= dev;
            state            <= T_EMIT;
          end
        end
        T_EMIT: begin
          if (out_free) begin
            m_tdata  <= {3'b000, held_ext[wsdm_pkg::HELD_W-1:0], last_dev[cur_ch]};
            m_tuser  <= {unsteady, cur_ch};
            state    <= T_IDLE;
          end
        end
        default: begin
          state <= T_IDLE;
        end
      endcase
    end
  end

  a_idle_means_unit_idle: assert property (@(posedge clk) disable iff (rst)
    (state == T_IDLE) |-> !status.busy && !status.done)
    else $error("statistics unit active while sequencer idle");

  a_done_only_in_calc: assert property (@(posedge clk) disable iff (rst)
    status.done |-> (state == T_CALC))
    else $error("deviation finished outside calculation");

  a_count_nonzero_on_output: assert property (@(posedge clk) disable iff (rst)
    (state == T_EMIT && out_free) |=> m_tvalid && (m_tdata[36:32] != 5'd0 || CW > 5))
    else $error("result posted with empty window");

endmodule
